FILE: src/plki_pkg.sv
// Package for the piecewise linear knot interpolator.
// Holds field widths, reset values, status codes, register offsets and the payload structs.
// Depends on nothing.
package plki_pkg;

	localparam int E_W = 24;
	localparam int A_W = 40;
	localparam int KIDX_W = 6;
	localparam int CNT_W = 7;
	localparam int MAX_KNOTS_DEF = 64;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic signed [E_W-1:0] WSTART_RST = 24'sd0;
	localparam logic signed [E_W-1:0] WSTOP_RST = 24'sd12800;
	localparam logic [CNT_W-1:0] KIU_RST = 7'd10;

	localparam logic [1:0] REG_WSTART = 2'd0;
	localparam logic [1:0] REG_WSTOP = 2'd1;
	localparam logic [1:0] REG_KIU = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_ZERO_W = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [KIDX_W-1:0] knot_index;
		logic signed [E_W-1:0] knot_energy;
		logic signed [A_W-1:0] knot_amplitude;
		logic signed [E_W-1:0] sample_energy;
	} in_item_t;

	typedef struct packed {
		logic signed [A_W-1:0] value;
		logic [1:0] status;
	} out_item_t;

endpackage

FILE: src/piecewise_linear_knot_interpolator.sv
// Piecewise linear knot interpolator: knot table, scan sequencer, shared multiplier and divider.
// A knot write or an energy outside the window goes straight to the result. Inside the window
// the steps are: scan of the knots, three table reads, setup, then, unless past the last knot or
// over a zero-width interval, two multiply passes, the divider steps and the saturate step; the
// result is presented last. One transaction is handled at a time, the next taken once the result
// is presented. Async reset clears the control state and the configuration registers.
module piecewise_linear_knot_interpolator #(
	parameter int MAX_KNOTS = plki_pkg::MAX_KNOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input plki_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output plki_pkg::out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [plki_pkg::PADDR_W-1:0] paddr,
	input logic [plki_pkg::PDATA_W-1:0] pwdata,
	output logic [plki_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import plki_pkg::*;

	// Index width of the table, and a count width that holds both the register and the depth.
	localparam int IDX_W = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int NW = (CNT_W > $clog2(MAX_KNOTS + 1)) ? CNT_W : $clog2(MAX_KNOTS + 1);
	localparam int D_W = E_W + 1;            // interval and offset width
	localparam int DA_W = A_W + 1;           // amplitude difference width
	localparam int LO_W = (DA_W + 1) / 2;    // low half of the amplitude magnitude
	localparam int P_W = DA_W + D_W;         // full product width
	localparam int Q_W = 42;                 // quotient bits below the cap
	localparam int V_W = A_W + 5;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_RDLO, S_RDHI, S_LATCH, S_SETUP, S_MUL0, S_MUL1, S_DIV, S_FIN, S_DONE
	} state_t;

	// Configuration registers. Writes complete on the access phase of the APB transaction.
	logic signed [E_W-1:0] wstart_q, wstop_q;
	logic [CNT_W-1:0] kiu_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wstart_q <= WSTART_RST;
			wstop_q <= WSTOP_RST;
			kiu_q <= KIU_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WSTART: wstart_q <= pwdata[E_W-1:0];
				REG_WSTOP: wstop_q <= pwdata[E_W-1:0];
				REG_KIU: kiu_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WSTART: prdata = PDATA_W'(wstart_q);
			REG_WSTOP: prdata = PDATA_W'(wstop_q);
			REG_KIU: prdata = PDATA_W'(kiu_q);
			default: prdata = '0;
		endcase
	end

	// Knot memory: one write port, one registered read port.
	logic signed [E_W-1:0] mem_e [MAX_KNOTS];
	logic signed [A_W-1:0] mem_a [MAX_KNOTS];
	logic signed [E_W-1:0] rd_e_q;
	logic signed [A_W-1:0] rd_a_q;
	logic [IDX_W-1:0] raddr, waddr;
	logic mem_we;

	state_t state_q;
	logic in_acc;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign waddr = IDX_W'(in_data.knot_index);
	assign mem_we = in_acc && (in_data.opcode == OP_WRITE)
		&& (int'(in_data.knot_index) < MAX_KNOTS);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_e[waddr] <= in_data.knot_energy;
			mem_a[waddr] <= in_data.knot_amplitude;
		end
		rd_e_q <= mem_e[raddr];
		rd_a_q <= mem_a[raddr];
	end

	// Sequencer state.
	logic signed [E_W-1:0] e_q;
	logic [NW-1:0] n_q, j_q;
	logic [IDX_W-1:0] at_q, pidx_q;
	logic pend_q, found_q;
	logic signed [E_W-1:0] a_e_q, b_e_q;
	logic signed [A_W-1:0] a_a_q, b_a_q, base_q;
	logic [DA_W-1:0] mda_q;
	logic [D_W-1:0] mnum_q, mden_q, r_q;
	logic neg_q;
	logic [P_W-1:0] p_q;
	logic [Q_W-1:0] q_q;
	logic big_q;
	logic [$clog2(P_W)-1:0] cnt_q;
	logic signed [A_W-1:0] res_v_q;
	logic [1:0] res_s_q;
	logic out_vld_q;
	out_item_t out_q;

	// Combinational helpers.
	logic last_knot;
	logic [NW-1:0] n_next, at_ext;
	logic signed [E_W-1:0] lo_e, hi_e;
	logic signed [A_W-1:0] lo_a, hi_a;
	logic signed [D_W-1:0] num, den;
	logic signed [DA_W-1:0] da;
	logic [LO_W-1:0] mul_a;
	logic [LO_W+D_W-1:0] pp;
	logic [D_W:0] r2;
	logic qbit;
	logic [Q_W:0] qmag;
	logic signed [Q_W+1:0] term;
	logic signed [V_W-1:0] vsum;
	logic out_free;

	assign n_next = (NW'(kiu_q) > NW'(MAX_KNOTS)) ? NW'(MAX_KNOTS) : NW'(kiu_q);
	assign at_ext = NW'(at_q);
	assign last_knot = found_q && !((at_ext + NW'(1)) < n_q);
	assign out_free = !out_vld_q || !out_stall;

	// Read address: scan pointer, then the lower knot (knot 0 when none is found), then the one above it.
	always_comb begin
		case (state_q)
			S_SCAN: raddr = j_q[IDX_W-1:0];
			S_RDLO: raddr = found_q ? at_q : '0;
			S_RDHI: raddr = at_q + IDX_W'(1);
			default: raddr = '0;
		endcase
	end

	// Without a knot below the energy the ramp starts at zero amplitude at the window onset.
	always_comb begin
		if (found_q) begin
			lo_e = a_e_q;
			lo_a = a_a_q;
			hi_e = b_e_q;
			hi_a = b_a_q;
		end else begin
			lo_e = wstart_q;
			lo_a = '0;
			hi_e = a_e_q;
			hi_a = a_a_q;
		end
		num = D_W'(e_q) - D_W'(lo_e);
		den = D_W'(hi_e) - D_W'(lo_e);
		da = DA_W'(hi_a) - DA_W'(lo_a);
	end

	// The one multiplier takes each half of the amplitude magnitude in turn.
	assign mul_a = (state_q == S_MUL1) ? LO_W'(mda_q[DA_W-1:LO_W]) : mda_q[LO_W-1:0];
	assign pp = mul_a * mnum_q;

	// Restoring division, one quotient bit a cycle, most significant first.
	assign r2 = {r_q, p_q[P_W-1]};
	assign qbit = (r2 >= {1'b0, mden_q});

	assign qmag = big_q ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_q};
	assign term = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	assign vsum = V_W'(base_q) + V_W'(term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_vld_q <= 1'b0;
			pend_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			// A waiting result in S_DONE reloads the output itself once it is taken.
			if (out_vld_q && !out_stall && (state_q != S_DONE))
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						e_q <= in_data.sample_energy;
						n_q <= n_next;
						j_q <= '0;
						pend_q <= 1'b0;
						found_q <= 1'b0;
						at_q <= '0;
						res_v_q <= '0;
						if (in_data.opcode == OP_WRITE) begin
							res_s_q <= ST_OK;
							state_q <= S_DONE;
						end else if (!(in_data.sample_energy > wstart_q
							&& in_data.sample_energy <= wstop_q)) begin
							res_s_q <= ST_OUTSIDE;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (j_q < n_q) begin
						pidx_q <= j_q[IDX_W-1:0];
						j_q <= j_q + NW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && (rd_e_q < e_q)) begin
						found_q <= 1'b1;
						at_q <= pidx_q;
					end
					if (!(j_q < n_q) && !pend_q)
						state_q <= S_RDLO;
				end
				S_RDLO: state_q <= S_RDHI;
				S_RDHI: begin
					a_e_q <= rd_e_q;
					a_a_q <= rd_a_q;
					state_q <= S_LATCH;
				end
				S_LATCH: begin
					b_e_q <= rd_e_q;
					b_a_q <= rd_a_q;
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					base_q <= lo_a;
					mda_q <= da[DA_W-1] ? DA_W'(-da) : DA_W'(da);
					mnum_q <= num[D_W-1] ? D_W'(-num) : D_W'(num);
					mden_q <= den[D_W-1] ? D_W'(-den) : D_W'(den);
					neg_q <= da[DA_W-1] ^ num[D_W-1] ^ den[D_W-1];
					if (last_knot) begin
						res_v_q <= a_a_q;
						res_s_q <= ST_OK;
						state_q <= S_DONE;
					end else if (den == '0) begin
						res_v_q <= '0;
						res_s_q <= ST_ZERO_W;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL0;
					end
				end
				S_MUL0: begin
					p_q <= P_W'(pp);
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					p_q <= p_q + (P_W'(pp) << LO_W);
					r_q <= '0;
					q_q <= '0;
					big_q <= 1'b0;
					cnt_q <= ($clog2(P_W))'(P_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					p_q <= p_q << 1;
					r_q <= qbit ? D_W'(r2 - {1'b0, mden_q}) : D_W'(r2);
					q_q <= {q_q[Q_W-2:0], qbit};
					if (qbit && (int'(cnt_q) >= Q_W))
						big_q <= 1'b1;
					if (cnt_q == '0)
						state_q <= S_FIN;
					else
						cnt_q <= cnt_q - ($clog2(P_W))'(1);
				end
				S_FIN: begin
					// The sum fits when every bit above the result's sign copies the sign.
					if (vsum[V_W-1:A_W-1] != {(V_W - A_W + 1){vsum[V_W-1]}}) begin
						res_v_q <= vsum[V_W-1] ? {1'b1, {(A_W - 1){1'b0}}}
							: {1'b0, {(A_W - 1){1'b1}}};
						res_s_q <= ST_SAT;
					end else begin
						res_v_q <= vsum[A_W-1:0];
						res_s_q <= ST_OK;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						out_q.value <= res_v_q;
						out_q.status <= res_s_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = out_q;

	// A transaction is never followed at once by another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// A result outside the window or over a zero-width interval is zero.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_OUTSIDE || out_data.status == ST_ZERO_W)
		|-> out_data.value == '0)
		else $error("non-zero value with zero status");

	// A saturated result sits on one of the two bounds.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_SAT
		|-> (out_data.value == {1'b0, {(A_W - 1){1'b1}}}
			|| out_data.value == {1'b1, {(A_W - 1){1'b0}}}))
		else $error("saturated value off the bound");

endmodule
